[hw/rtl/assert_macros.svh]
// Assertion macros shared by the array linked list manager RTL.
// Assertions are checked in simulation and compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ALM_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ALM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ALM_ASSERT(label, clk, rstn, prop)
`define ALM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[hw/rtl/alm_pkg.sv]
// Package for the array linked list manager: sizes, codes, types and helpers.
// Used by the interfaces, the controller and the top level.
package alm_pkg;

  localparam int unsigned Capacity = 16;
  localparam int SlotW = $clog2(Capacity + 1);
  localparam int IdxW = $clog2(Capacity);
  localparam int ValueW = 32;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic signed [ValueW-1:0] value_t;

  localparam slot_t NoneSlot = SlotW'(Capacity);

  typedef enum logic {
    KindInsert = 1'b0,
    KindDelete = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StatusInserted = 2'd0,
    StatusDeleted  = 2'd1,
    StatusNoMatch  = 2'd2,
    StatusFull     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    FsmInit,
    FsmIdle,
    FsmInsLink,
    FsmInsFixNext,
    FsmInsFixHead,
    FsmDelRead,
    FsmDelCheck,
    FsmDelFixPrev,
    FsmDelFixNext,
    FsmDelFreeHead,
    FsmDelFreeSlot,
    FsmResp
  } state_e;

  typedef struct packed {
    slot_t nxt;
    slot_t prv;
  } link_t;

  localparam int LinkW = $bits(link_t);

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    link_t wmask;
    link_t wdata;
    idx_t  raddr;
  } link_req_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    idx_t   raddr;
  } val_req_t;

  function automatic logic is_slot(slot_t s);
    return s < NoneSlot;
  endfunction

  function automatic slot_t norm_slot(slot_t s);
    return is_slot(s) ? s : NoneSlot;
  endfunction

endpackage

[hw/rtl/alm_in_if.sv]
// Request channel of the array linked list manager: operation kind and value.
// Depends on alm_pkg for the payload types.
interface alm_in_if import alm_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_e  kind;
  value_t value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

[hw/rtl/alm_out_if.sv]
// Response channel of the array linked list manager: status and slot index.
// Depends on alm_pkg for the payload types.
interface alm_out_if import alm_pkg::*; ();
  logic    valid;
  logic    ready;
  status_e status;
  slot_t   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink (input valid, input status, input slot, output ready);
endinterface

[hw/rtl/alm_ram.sv]
// Generic synchronous RAM with a bit write mask and a registered read port.
// One write and one read per cycle; read data is registered and appears in the cycle after the address.
module alm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wmask_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < Width; b++) begin
        if (wmask_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i[b];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/alm_ctrl.sv]
// Sequencer of the array linked list manager: link initialization, insert,
// delete walk, unlink and free-list return. Depends on alm_pkg and the interfaces.
`include "assert_macros.svh"

module alm_ctrl import alm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  alm_in_if.sink    req_i,
  alm_out_if.source rsp_o,
  output link_req_t link_req_o,
  input  link_t     link_rdata_i,
  output val_req_t  val_req_o,
  input  value_t    val_rdata_i
);

  state_e  state_q, state_d;
  idx_t    init_q, init_d;
  value_t  op_value_q, op_value_d;
  slot_t   cur_q, cur_d;
  slot_t   steps_q, steps_d;
  slot_t   prev_q, prev_d;
  slot_t   next_q, next_d;
  slot_t   list_head_q, list_head_d;
  slot_t   free_head_q, free_head_d;
  status_e res_status_q, res_status_d;
  slot_t   res_slot_q, res_slot_d;
  logic    out_valid_q, out_valid_d;
  status_e out_status_q, out_status_d;
  slot_t   out_slot_q, out_slot_d;

  logic req_fire;
  logic walk_done;
  logic out_free;

  assign req_fire  = req_i.valid && req_i.ready;
  assign walk_done = !is_slot(cur_q) || (steps_q == NoneSlot);
  assign out_free  = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmInit: begin
        if (init_q == IdxW'(Capacity - 1)) begin
          state_d = FsmIdle;
        end
      end
      FsmIdle: begin
        if (req_fire) begin
          if (req_i.kind == KindInsert) begin
            state_d = is_slot(free_head_q) ? FsmInsLink : FsmResp;
          end else begin
            state_d = FsmDelRead;
          end
        end
      end
      FsmInsLink:     state_d = FsmInsFixNext;
      FsmInsFixNext:  state_d = FsmInsFixHead;
      FsmInsFixHead:  state_d = FsmResp;
      FsmDelRead:     state_d = walk_done ? FsmResp : FsmDelCheck;
      FsmDelCheck:    state_d = (val_rdata_i == op_value_q) ? FsmDelFixPrev : FsmDelRead;
      FsmDelFixPrev:  state_d = FsmDelFixNext;
      FsmDelFixNext:  state_d = FsmDelFreeHead;
      FsmDelFreeHead: state_d = FsmDelFreeSlot;
      FsmDelFreeSlot: state_d = FsmResp;
      FsmResp: begin
        if (out_free) begin
          state_d = FsmIdle;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end

  always_comb begin
    init_d       = init_q;
    op_value_d   = op_value_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    prev_d       = prev_q;
    next_d       = next_q;
    list_head_d  = list_head_q;
    free_head_d  = free_head_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;

    link_req_o       = '0;
    link_req_o.raddr = free_head_q[IdxW-1:0];
    val_req_o        = '0;
    val_req_o.raddr  = cur_q[IdxW-1:0];

    unique case (state_q)
      FsmInit: begin
        link_req_o.we        = 1'b1;
        link_req_o.waddr     = init_q;
        link_req_o.wmask     = '1;
        link_req_o.wdata.nxt = (init_q == IdxW'(Capacity - 1)) ?
                               NoneSlot : SlotW'(init_q) + SlotW'(1);
        link_req_o.wdata.prv = (init_q == '0) ? NoneSlot : SlotW'(init_q) - SlotW'(1);
        init_d               = init_q + IdxW'(1);
      end
      FsmIdle: begin
        if (req_fire) begin
          op_value_d = req_i.value;
          steps_d    = '0;
          if (req_i.kind == KindInsert) begin
            cur_d        = free_head_q;
            res_status_d = StatusFull;
            res_slot_d   = NoneSlot;
          end else begin
            cur_d = list_head_q;
          end
        end
      end
      FsmInsLink: begin
        next_d               = link_rdata_i.nxt;
        link_req_o.we        = 1'b1;
        link_req_o.waddr     = cur_q[IdxW-1:0];
        link_req_o.wmask     = '1;
        link_req_o.wdata.nxt = norm_slot(list_head_q);
        link_req_o.wdata.prv = NoneSlot;
        val_req_o.we         = 1'b1;
        val_req_o.waddr      = cur_q[IdxW-1:0];
        val_req_o.wdata      = op_value_q;
      end
      FsmInsFixNext: begin
        if (is_slot(next_q)) begin
          link_req_o.we        = 1'b1;
          link_req_o.waddr     = next_q[IdxW-1:0];
          link_req_o.wmask.prv = '1;
          link_req_o.wdata.prv = NoneSlot;
        end
      end
      FsmInsFixHead: begin
        if (is_slot(list_head_q)) begin
          link_req_o.we        = 1'b1;
          link_req_o.waddr     = list_head_q[IdxW-1:0];
          link_req_o.wmask.prv = '1;
          link_req_o.wdata.prv = cur_q;
        end
        list_head_d  = cur_q;
        free_head_d  = norm_slot(next_q);
        res_status_d = StatusInserted;
        res_slot_d   = cur_q;
      end
      FsmDelRead: begin
        link_req_o.raddr = cur_q[IdxW-1:0];
        if (walk_done) begin
          res_status_d = StatusNoMatch;
          res_slot_d   = NoneSlot;
        end
      end
      FsmDelCheck: begin
        if (val_rdata_i == op_value_q) begin
          prev_d = norm_slot(link_rdata_i.prv);
          next_d = norm_slot(link_rdata_i.nxt);
        end else begin
          cur_d   = link_rdata_i.nxt;
          steps_d = steps_q + SlotW'(1);
        end
      end
      FsmDelFixPrev: begin
        if (is_slot(prev_q)) begin
          link_req_o.we        = 1'b1;
          link_req_o.waddr     = prev_q[IdxW-1:0];
          link_req_o.wmask.nxt = '1;
          link_req_o.wdata.nxt = next_q;
        end else begin
          list_head_d = next_q;
        end
      end
      FsmDelFixNext: begin
        if (is_slot(next_q)) begin
          link_req_o.we        = 1'b1;
          link_req_o.waddr     = next_q[IdxW-1:0];
          link_req_o.wmask.prv = '1;
          link_req_o.wdata.prv = prev_q;
        end
      end
      FsmDelFreeHead: begin
        if (is_slot(free_head_q)) begin
          link_req_o.we        = 1'b1;
          link_req_o.waddr     = free_head_q[IdxW-1:0];
          link_req_o.wmask.prv = '1;
          link_req_o.wdata.prv = cur_q;
        end
      end
      FsmDelFreeSlot: begin
        link_req_o.we        = 1'b1;
        link_req_o.waddr     = cur_q[IdxW-1:0];
        link_req_o.wmask     = '1;
        link_req_o.wdata.nxt = free_head_q;
        link_req_o.wdata.prv = NoneSlot;
        free_head_d          = cur_q;
        res_status_d         = StatusDeleted;
        res_slot_d           = cur_q;
      end
      FsmResp: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmInit;
      init_q      <= '0;
      list_head_q <= NoneSlot;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_value_q   <= op_value_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    prev_q       <= prev_d;
    next_q       <= next_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  assign req_i.ready  = (state_q == FsmIdle);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.slot   = out_slot_q;

  // The two chains never share their head slot.
  `ALM_ASSERT(a_heads_disjoint, clk_i, rst_ni, !(is_slot(list_head_q) && (list_head_q == free_head_q)))
  // The delete walk never counts past the number of slots.
  `ALM_ASSERT(a_steps_bounded, clk_i, rst_ni, (state_q == FsmDelCheck) |-> (steps_q < NoneSlot))
  // Link memory is left alone while waiting for work or for the response slot.
  `ALM_ASSERT(a_no_write_idle, clk_i, rst_ni, (state_q == FsmIdle || state_q == FsmResp) |-> !link_req_o.we)
  // An accepted transaction always leaves the idle state.
  `ALM_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, req_fire |=> (state_q != FsmIdle))
  // A response only appears out of the response state.
  `ALM_ASSERT_ALWAYS(a_resp_source, clk_i, $rose(out_valid_q) |-> ($past(state_q) == FsmResp))

endmodule

[hw/rtl/array_linked_list_manager.sv]
// Insert: link and value write, free-list successor fix, list head fix, then response;
// a full list goes straight to the response. Delete: each visited slot is read and then
// checked; a match is followed by the unlink and free-list writes and the response.
// One item is in work at a time; the response register frees the request side early.
// After reset the link memory is initialized, all slots chained into the free list, before the first request.
// Top level: holds the link and value memories and the sequencer; depends on alm_pkg.
module array_linked_list_manager import alm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  alm_in_if.sink    req_i,
  alm_out_if.source rsp_o
);

  link_req_t link_req;
  link_t     link_rdata;
  val_req_t  val_req;
  value_t    val_rdata;

  alm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata),
    .val_req_o    (val_req),
    .val_rdata_i  (val_rdata)
  );

  alm_ram #(
    .Width (LinkW),
    .Depth (Capacity)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_req.we),
    .waddr_i (link_req.waddr),
    .wmask_i (link_req.wmask),
    .wdata_i (link_req.wdata),
    .raddr_i (link_req.raddr),
    .rdata_o (link_rdata)
  );

  alm_ram #(
    .Width (ValueW),
    .Depth (Capacity)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_req.we),
    .waddr_i (val_req.waddr),
    .wmask_i ({ValueW{1'b1}}),
    .wdata_i (val_req.wdata),
    .raddr_i (val_req.raddr),
    .rdata_o (val_rdata)
  );

endmodule
